// File: src/ppcdec_pkg.sv
// package for the powerpc instruction decoder: decode tables and functions
package ppcdec_pkg;

  localparam int WordW = 32;
  localparam int OpW   = 8;
  localparam int TdataOutW = 48;

  localparam logic [5:0] Pri19 = 6'b010011;
  localparam logic [5:0] Pri31 = 6'b011111;
  localparam logic [5:0] Pri59 = 6'b111011;
  localparam logic [5:0] Pri63 = 6'b111111;
  localparam logic [OpW-1:0] OpUndef = 8'd0;
  localparam logic [OpW-1:0] OpSc = 8'd210;
  localparam logic [WordW-1:0] ScMask  = 32'hFC000002;
  localparam logic [WordW-1:0] ScMatch = 32'h44000002;

  typedef enum logic [1:0] {
    GATE_NONE = 2'd0,
    GATE_64   = 2'd1,
    GATE_32   = 2'd2
  } gate_t;

  typedef struct packed {
    logic            hit;
    logic [OpW-1:0]  op;
    gate_t           gate;
    logic            sup;
  } entry_t;

  localparam entry_t Miss = '{hit: 1'b0, op: OpUndef, gate: GATE_NONE, sup: 1'b0};

  function automatic entry_t mk(input int op, input gate_t g, input logic s);
    entry_t e;
    e.hit  = 1'b1;
    e.op   = OpW'(op);
    e.gate = g;
    e.sup  = s;
    return e;
  endfunction

  // primary opcode only
  function automatic entry_t pass_one(input logic [5:0] p);
    entry_t e;
    e = Miss;
    case (p)
      6'b000010: e = mk(1, GATE_64, 1'b0);
      6'b000011: e = mk(2, GATE_NONE, 1'b0);
      6'b000111: e = mk(3, GATE_NONE, 1'b0);
      6'b001000: e = mk(4, GATE_NONE, 1'b0);
      6'b001100: e = mk(5, GATE_NONE, 1'b0);
      6'b001101: e = mk(6, GATE_NONE, 1'b0);
      6'b001110: e = mk(7, GATE_NONE, 1'b0);
      6'b001111: e = mk(8, GATE_NONE, 1'b0);
      6'b010000: e = mk(9, GATE_NONE, 1'b0);
      6'b010010: e = mk(10, GATE_NONE, 1'b0);
      6'b010100: e = mk(11, GATE_NONE, 1'b0);
      6'b010101: e = mk(12, GATE_NONE, 1'b0);
      6'b010111: e = mk(13, GATE_NONE, 1'b0);
      6'b011000: e = mk(14, GATE_NONE, 1'b0);
      6'b011001: e = mk(15, GATE_NONE, 1'b0);
      6'b011010: e = mk(16, GATE_NONE, 1'b0);
      6'b011011: e = mk(17, GATE_NONE, 1'b0);
      6'b011100: e = mk(18, GATE_NONE, 1'b0);
      6'b011101: e = mk(19, GATE_NONE, 1'b0);
      6'b100000: e = mk(20, GATE_NONE, 1'b0);
      6'b100001: e = mk(21, GATE_NONE, 1'b0);
      6'b100010: e = mk(22, GATE_NONE, 1'b0);
      6'b100011: e = mk(23, GATE_NONE, 1'b0);
      6'b100100: e = mk(24, GATE_NONE, 1'b0);
      6'b100101: e = mk(25, GATE_NONE, 1'b0);
      6'b100110: e = mk(26, GATE_NONE, 1'b0);
      6'b100111: e = mk(27, GATE_NONE, 1'b0);
      6'b101000: e = mk(28, GATE_NONE, 1'b0);
      6'b101001: e = mk(29, GATE_NONE, 1'b0);
      6'b101010: e = mk(30, GATE_NONE, 1'b0);
      6'b101011: e = mk(31, GATE_NONE, 1'b0);
      6'b101100: e = mk(32, GATE_NONE, 1'b0);
      6'b101101: e = mk(33, GATE_NONE, 1'b0);
      6'b101110: e = mk(34, GATE_NONE, 1'b0);
      6'b101111: e = mk(35, GATE_NONE, 1'b0);
      6'b110000: e = mk(36, GATE_NONE, 1'b0);
      6'b110001: e = mk(37, GATE_NONE, 1'b0);
      6'b110010: e = mk(38, GATE_NONE, 1'b0);
      6'b110011: e = mk(39, GATE_NONE, 1'b0);
      6'b110100: e = mk(40, GATE_NONE, 1'b0);
      6'b110101: e = mk(41, GATE_NONE, 1'b0);
      6'b110110: e = mk(42, GATE_NONE, 1'b0);
      6'b110111: e = mk(43, GATE_NONE, 1'b0);
      6'b001010: e = mk(44, GATE_NONE, 1'b0);
      6'b001011: e = mk(45, GATE_NONE, 1'b0);
      default:   e = Miss;
    endcase
    return e;
  endfunction

  function automatic entry_t pass_two_19(input logic [9:0] x);
    entry_t e;
    e = Miss;
    case (x)
      10'b0000000000: e = mk(65, GATE_NONE, 1'b0);
      10'b0000010000: e = mk(66, GATE_NONE, 1'b0);
      10'b0000100001: e = mk(67, GATE_NONE, 1'b0);
      10'b0000110010: e = mk(68, GATE_NONE, 1'b0);
      10'b0010000001: e = mk(69, GATE_NONE, 1'b0);
      10'b0010010110: e = mk(70, GATE_NONE, 1'b0);
      10'b0011000001: e = mk(71, GATE_NONE, 1'b0);
      10'b0011100001: e = mk(72, GATE_NONE, 1'b0);
      10'b0100000001: e = mk(73, GATE_NONE, 1'b0);
      10'b0100100001: e = mk(74, GATE_NONE, 1'b0);
      10'b0110100001: e = mk(75, GATE_NONE, 1'b0);
      10'b0111000001: e = mk(76, GATE_NONE, 1'b0);
      10'b1000010000: e = mk(77, GATE_NONE, 1'b0);
      default:        e = Miss;
    endcase
    return e;
  endfunction

  function automatic entry_t pass_two_31(input logic [9:0] x);
    entry_t e;
    e = Miss;
    case (x)
      10'b0000001001: e = mk(46, GATE_64, 1'b0);
      10'b0000010101: e = mk(47, GATE_64, 1'b0);
      10'b0000011011: e = mk(48, GATE_64, 1'b0);
      10'b0000110101: e = mk(49, GATE_64, 1'b0);
      10'b0000111010: e = mk(50, GATE_64, 1'b0);
      10'b0001000100: e = mk(51, GATE_64, 1'b0);
      10'b0001001001: e = mk(52, GATE_64, 1'b0);
      10'b0001010100: e = mk(53, GATE_64, 1'b0);
      10'b0010010101: e = mk(54, GATE_64, 1'b0);
      10'b0010110101: e = mk(55, GATE_64, 1'b0);
      10'b0011101001: e = mk(56, GATE_64, 1'b0);
      10'b1011101001: e = mk(56, GATE_64, 1'b0);
      10'b0101010101: e = mk(57, GATE_64, 1'b0);
      10'b0101110101: e = mk(58, GATE_64, 1'b0);
      10'b0110110010: e = mk(59, GATE_64, 1'b0);
      10'b0111001001: e = mk(60, GATE_64, 1'b0);
      10'b1111001001: e = mk(60, GATE_64, 1'b0);
      10'b0111101001: e = mk(61, GATE_64, 1'b0);
      10'b1111101001: e = mk(61, GATE_64, 1'b0);
      10'b1000011011: e = mk(62, GATE_64, 1'b0);
      10'b1100011010: e = mk(63, GATE_64, 1'b0);
      10'b1111011010: e = mk(64, GATE_64, 1'b0);
      10'b0000000000: e = mk(78, GATE_NONE, 1'b0);
      10'b0000000100: e = mk(79, GATE_NONE, 1'b0);
      10'b0000001000: e = mk(80, GATE_NONE, 1'b0);
      10'b1000001000: e = mk(80, GATE_NONE, 1'b0);
      10'b0000001010: e = mk(81, GATE_NONE, 1'b0);
      10'b1000001010: e = mk(81, GATE_NONE, 1'b0);
      10'b0000001011: e = mk(82, GATE_NONE, 1'b0);
      10'b0000010011: e = mk(83, GATE_NONE, 1'b0);
      10'b0000010100: e = mk(84, GATE_NONE, 1'b0);
      10'b0000010111: e = mk(85, GATE_NONE, 1'b0);
      10'b0000011000: e = mk(86, GATE_NONE, 1'b0);
      10'b0000011010: e = mk(87, GATE_NONE, 1'b0);
      10'b0000011100: e = mk(88, GATE_NONE, 1'b0);
      10'b0000100000: e = mk(89, GATE_NONE, 1'b0);
      10'b0000101000: e = mk(90, GATE_NONE, 1'b0);
      10'b1000101000: e = mk(90, GATE_NONE, 1'b0);
      10'b0000110110: e = mk(91, GATE_NONE, 1'b0);
      10'b0000110111: e = mk(92, GATE_NONE, 1'b0);
      10'b0000111100: e = mk(93, GATE_NONE, 1'b0);
      10'b0001001011: e = mk(94, GATE_NONE, 1'b0);
      10'b0001010011: e = mk(95, GATE_NONE, 1'b0);
      10'b0001010110: e = mk(96, GATE_NONE, 1'b0);
      10'b0001010111: e = mk(97, GATE_NONE, 1'b0);
      10'b0001101000: e = mk(98, GATE_NONE, 1'b0);
      10'b1001101000: e = mk(98, GATE_NONE, 1'b0);
      10'b0001110111: e = mk(99, GATE_NONE, 1'b0);
      10'b0001111100: e = mk(100, GATE_NONE, 1'b0);
      10'b0010001000: e = mk(101, GATE_NONE, 1'b0);
      10'b1010001000: e = mk(101, GATE_NONE, 1'b0);
      10'b0010001010: e = mk(102, GATE_NONE, 1'b0);
      10'b1010001010: e = mk(102, GATE_NONE, 1'b0);
      10'b0010010000: e = mk(103, GATE_NONE, 1'b0);
      10'b0010010010: e = mk(104, GATE_NONE, 1'b0);
      10'b0010010111: e = mk(105, GATE_NONE, 1'b0);
      10'b0010110111: e = mk(106, GATE_NONE, 1'b0);
      10'b0011001000: e = mk(107, GATE_NONE, 1'b0);
      10'b1011001000: e = mk(107, GATE_NONE, 1'b0);
      10'b0011001010: e = mk(108, GATE_NONE, 1'b0);
      10'b1011001010: e = mk(108, GATE_NONE, 1'b0);
      10'b0011010111: e = mk(109, GATE_NONE, 1'b0);
      10'b0011101000: e = mk(110, GATE_NONE, 1'b0);
      10'b1011101000: e = mk(110, GATE_NONE, 1'b0);
      10'b0011101010: e = mk(111, GATE_NONE, 1'b0);
      10'b1011101010: e = mk(111, GATE_NONE, 1'b0);
      10'b0011101011: e = mk(112, GATE_NONE, 1'b0);
      10'b1011101011: e = mk(112, GATE_NONE, 1'b0);
      10'b0011110110: e = mk(113, GATE_NONE, 1'b0);
      10'b0011110111: e = mk(114, GATE_NONE, 1'b0);
      10'b0100001010: e = mk(115, GATE_NONE, 1'b0);
      10'b1100001010: e = mk(115, GATE_NONE, 1'b0);
      10'b0100010110: e = mk(116, GATE_NONE, 1'b0);
      10'b0100010111: e = mk(117, GATE_NONE, 1'b0);
      10'b0100011100: e = mk(118, GATE_NONE, 1'b0);
      10'b0100110110: e = mk(119, GATE_NONE, 1'b0);
      10'b0100110111: e = mk(120, GATE_NONE, 1'b0);
      10'b0100111100: e = mk(121, GATE_NONE, 1'b0);
      10'b0101010111: e = mk(122, GATE_NONE, 1'b0);
      10'b0101110011: e = mk(123, GATE_NONE, 1'b0);
      10'b0101110111: e = mk(124, GATE_NONE, 1'b0);
      10'b0110010111: e = mk(125, GATE_NONE, 1'b0);
      10'b0110011100: e = mk(126, GATE_NONE, 1'b0);
      10'b0110110110: e = mk(127, GATE_NONE, 1'b0);
      10'b0110110111: e = mk(128, GATE_NONE, 1'b0);
      10'b0110111100: e = mk(129, GATE_NONE, 1'b0);
      10'b0111001011: e = mk(130, GATE_NONE, 1'b0);
      10'b1111001011: e = mk(130, GATE_NONE, 1'b0);
      10'b0111010110: e = mk(131, GATE_NONE, 1'b0);
      10'b0111011100: e = mk(132, GATE_NONE, 1'b0);
      10'b0111101011: e = mk(133, GATE_NONE, 1'b0);
      10'b1111101011: e = mk(133, GATE_NONE, 1'b0);
      10'b1000000000: e = mk(134, GATE_NONE, 1'b0);
      10'b1000010101: e = mk(135, GATE_NONE, 1'b0);
      10'b1000010110: e = mk(136, GATE_NONE, 1'b0);
      10'b1000010111: e = mk(137, GATE_NONE, 1'b0);
      10'b1000011000: e = mk(138, GATE_NONE, 1'b0);
      10'b1000110111: e = mk(139, GATE_NONE, 1'b0);
      10'b1001010101: e = mk(140, GATE_NONE, 1'b0);
      10'b1001010110: e = mk(141, GATE_NONE, 1'b0);
      10'b1001010111: e = mk(142, GATE_NONE, 1'b0);
      10'b1001110111: e = mk(143, GATE_NONE, 1'b0);
      10'b1010010101: e = mk(144, GATE_NONE, 1'b0);
      10'b1010010110: e = mk(145, GATE_NONE, 1'b0);
      10'b1010010111: e = mk(146, GATE_NONE, 1'b0);
      10'b1010110111: e = mk(147, GATE_NONE, 1'b0);
      10'b1011010101: e = mk(148, GATE_NONE, 1'b0);
      10'b1011010111: e = mk(149, GATE_NONE, 1'b0);
      10'b1011110111: e = mk(150, GATE_NONE, 1'b0);
      10'b1100010110: e = mk(151, GATE_NONE, 1'b0);
      10'b1100011000: e = mk(152, GATE_NONE, 1'b0);
      10'b1100111000: e = mk(153, GATE_NONE, 1'b0);
      10'b1101010110: e = mk(154, GATE_NONE, 1'b0);
      10'b1110010110: e = mk(155, GATE_NONE, 1'b0);
      10'b1110011010: e = mk(156, GATE_NONE, 1'b0);
      10'b1110111010: e = mk(157, GATE_NONE, 1'b0);
      10'b1111010110: e = mk(158, GATE_NONE, 1'b0);
      10'b1111010111: e = mk(159, GATE_NONE, 1'b0);
      10'b1111110110: e = mk(160, GATE_NONE, 1'b0);
      10'b0101010011: e = mk(179, GATE_NONE, 1'b0);
      10'b0111010011: e = mk(180, GATE_NONE, 1'b0);
      10'b0011010010: e = mk(181, GATE_32, 1'b1);
      10'b0011110010: e = mk(182, GATE_32, 1'b1);
      10'b1001010011: e = mk(183, GATE_32, 1'b1);
      10'b1010010011: e = mk(184, GATE_32, 1'b1);
      10'b0111110010: e = mk(185, GATE_64, 1'b1);
      10'b0100110010: e = mk(186, GATE_NONE, 1'b1);
      10'b0101110010: e = mk(187, GATE_NONE, 1'b1);
      10'b1000110110: e = mk(188, GATE_NONE, 1'b1);
      default:        e = Miss;
    endcase
    return e;
  endfunction

  function automatic entry_t pass_two_63(input logic [9:0] x);
    entry_t e;
    e = Miss;
    case (x)
      10'b0000000000: e = mk(161, GATE_NONE, 1'b0);
      10'b0000001100: e = mk(162, GATE_NONE, 1'b0);
      10'b0000001110: e = mk(163, GATE_NONE, 1'b0);
      10'b0000001111: e = mk(164, GATE_NONE, 1'b0);
      10'b0000100000: e = mk(165, GATE_NONE, 1'b0);
      10'b0000100110: e = mk(166, GATE_NONE, 1'b0);
      10'b0000101000: e = mk(167, GATE_NONE, 1'b0);
      10'b0001000000: e = mk(168, GATE_NONE, 1'b0);
      10'b0001000110: e = mk(169, GATE_NONE, 1'b0);
      10'b0001001000: e = mk(170, GATE_NONE, 1'b0);
      10'b0010000110: e = mk(171, GATE_NONE, 1'b0);
      10'b0010001000: e = mk(172, GATE_NONE, 1'b0);
      10'b0100001000: e = mk(173, GATE_NONE, 1'b0);
      10'b1001000111: e = mk(174, GATE_NONE, 1'b0);
      10'b1011000111: e = mk(175, GATE_NONE, 1'b0);
      10'b1100101110: e = mk(176, GATE_NONE, 1'b0);
      10'b1100101111: e = mk(177, GATE_NONE, 1'b0);
      10'b1101001110: e = mk(178, GATE_NONE, 1'b0);
      default:        e = Miss;
    endcase
    return e;
  endfunction

  function automatic entry_t pass_three_59(input logic [4:0] x);
    entry_t e;
    e = Miss;
    case (x)
      5'b10010: e = mk(189, GATE_NONE, 1'b0);
      5'b10100: e = mk(190, GATE_NONE, 1'b0);
      5'b10101: e = mk(191, GATE_NONE, 1'b0);
      5'b11001: e = mk(192, GATE_NONE, 1'b0);
      5'b11100: e = mk(193, GATE_NONE, 1'b0);
      5'b11101: e = mk(194, GATE_NONE, 1'b0);
      5'b11110: e = mk(195, GATE_NONE, 1'b0);
      5'b11111: e = mk(196, GATE_NONE, 1'b0);
      5'b10110: e = mk(205, GATE_64, 1'b0);
      5'b11000: e = mk(206, GATE_64, 1'b0);
      default:  e = Miss;
    endcase
    return e;
  endfunction

  function automatic entry_t pass_three_63(input logic [4:0] x);
    entry_t e;
    e = Miss;
    case (x)
      5'b10010: e = mk(197, GATE_NONE, 1'b0);
      5'b10100: e = mk(198, GATE_NONE, 1'b0);
      5'b10101: e = mk(199, GATE_NONE, 1'b0);
      5'b11001: e = mk(200, GATE_NONE, 1'b0);
      5'b11100: e = mk(201, GATE_NONE, 1'b0);
      5'b11101: e = mk(202, GATE_NONE, 1'b0);
      5'b11110: e = mk(203, GATE_NONE, 1'b0);
      5'b11111: e = mk(204, GATE_NONE, 1'b0);
      5'b10110: e = mk(207, GATE_NONE, 1'b0);
      5'b10111: e = mk(208, GATE_NONE, 1'b0);
      5'b11010: e = mk(209, GATE_NONE, 1'b0);
      default:  e = Miss;
    endcase
    return e;
  endfunction

endpackage

// File: src/powerpc_instruction_decoder_unit.sv
// powerpc instruction decoder: input register, table decode, result register
//
// channel   dir  payload
// s_axis    in   tdata[31:0] instruction_word
// m_axis    out  tdata[7:0] operation, [8] supervisor_only, [40:9] word_out
// cfg       in   data: model_is_64bit
//
// one word per cycle while m_axis_tready keeps up; each word passes the input register, then the result register
// the table decode sits between the input register and the result register
// rst clears both valid bits and model_is_64bit
// each stage holds while the one after it is full and stalled
module powerpc_instruction_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ppcdec_pkg::WordW-1:0]        s_axis_tdata,  // instruction_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // operation, supervisor_only, word_out
  output logic [ppcdec_pkg::TdataOutW-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);
  import ppcdec_pkg::*;

  logic             model_is_64bit;
  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             out_valid;
  logic [OpW-1:0]   out_op;
  logic             out_sup;
  logic [WordW-1:0] out_word;

  logic             out_load;
  logic             in_load;
  entry_t           e1, e2, e3, hit;
  logic [OpW-1:0]   op_next;
  logic             sup_next;
  logic [5:0]       pri;
  logic             gate_fail;

  assign cfg_ready     = 1'b1;
  assign out_load      = !out_valid || m_axis_tready;
  assign in_load       = !in_valid || out_load;
  assign s_axis_tready = in_load;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_word, out_sup, out_op};

  assign pri = in_word[31:26];

  always_comb begin
    e1 = pass_one(pri);
    case (pri)
      Pri19:   e2 = pass_two_19(in_word[10:1]);
      Pri31:   e2 = pass_two_31(in_word[10:1]);
      Pri63:   e2 = pass_two_63(in_word[10:1]);
      default: e2 = Miss;
    endcase
    case (pri)
      Pri59:   e3 = pass_three_59(in_word[5:1]);
      Pri63:   e3 = pass_three_63(in_word[5:1]);
      default: e3 = Miss;
    endcase
    if (e1.hit) begin
      hit = e1;
    end else if (e2.hit) begin
      hit = e2;
    end else begin
      hit = e3;
    end
    gate_fail = (hit.gate == GATE_64 && !model_is_64bit) ||
                (hit.gate == GATE_32 && model_is_64bit);
    if (hit.hit) begin
      op_next  = gate_fail ? OpUndef : hit.op;
      sup_next = gate_fail ? 1'b0 : hit.sup;
    end else if ((in_word & ScMask) == ScMatch) begin
      op_next  = OpSc;
      sup_next = 1'b0;
    end else begin
      op_next  = OpUndef;
      sup_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_is_64bit <= 1'b0;
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        model_is_64bit <= cfg_data;
      end
      if (in_load) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_axis_tvalid) begin
      in_word <= s_axis_tdata;
    end
    if (out_load && in_valid) begin
      out_op   <= op_next;
      out_sup  <= sup_next;
      out_word <= in_word;
    end
  end

  a_sup_needs_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sup |-> out_op != OpUndef) else $error("sup without op");
  a_word_passes: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_load |=> out_word == $past(in_word)) else $error("word lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_op)) else $error("result dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_op <= OpSc) else $error("op out of range");

endmodule

// File: sim/powerpc_instruction_decoder_unit_test.sv
// self-checking testbench for the powerpc instruction decoder unit
module powerpc_instruction_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppcdec_pkg::*;

  localparam logic [9:0] Xo31List [0:13] = '{10'b0000001001, 10'b0011101001, 10'b1111011010,
    10'b0000000000, 10'b1000001000, 10'b1111110110, 10'b0011010010, 10'b1010010011,
    10'b0111110010, 10'b0100110010, 10'b1000110110, 10'b0101010011, 10'b0000010101,
    10'b1000011011};
  localparam logic [4:0] Xo5List [0:5] = '{5'b10010, 5'b10110, 5'b11000, 5'b10111,
    5'b11010, 5'b11111};

  typedef struct {
    logic        cfg_wr;
    logic        cfg_val;
    logic [31:0] word;
    logic        typed;
    logic [7:0]  exp_op;
    logic        exp_sup;
  } row_t;

  typedef struct {
    logic [7:0]  op;
    logic        sup;
    logic [31:0] word;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [WordW-1:0] s_axis_tdata = '0;  // instruction_word
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;  // operation, supervisor_only, word_out
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  decoded_t pending_decodes[$];
  logic     is_64bit = 1'b0;
  int       errors = 0;
  int       table_errors = 0;
  int       cycles = 0;
  int       send_idle = 0;
  int       recv_stall = 0;
  row_t     rows[$];

  powerpc_instruction_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("powerpc_instruction_decoder_unit: mismatch");
      $finish;
    end
  end

  function automatic entry_t lookup_entry(input logic [5:0] p, input logic [9:0] x10,
                                          input logic [4:0] x5, output logic found);
    entry_t e;
    e = Miss;
    found = 1'b1;
    case (p)
      6'b000010: e = mk(1, GATE_64, 1'b0);
      6'b000011, 6'b000111, 6'b001000, 6'b001100, 6'b001101, 6'b001110, 6'b001111,
      6'b010000, 6'b010010, 6'b010100, 6'b010101, 6'b010111, 6'b011000, 6'b011001,
      6'b011010, 6'b011011, 6'b011100, 6'b011101: begin
        case (p)
          6'b000011: e = mk(2, GATE_NONE, 1'b0);
          6'b000111: e = mk(3, GATE_NONE, 1'b0);
          6'b001000: e = mk(4, GATE_NONE, 1'b0);
          6'b001100: e = mk(5, GATE_NONE, 1'b0);
          6'b001101: e = mk(6, GATE_NONE, 1'b0);
          6'b001110: e = mk(7, GATE_NONE, 1'b0);
          6'b001111: e = mk(8, GATE_NONE, 1'b0);
          6'b010000: e = mk(9, GATE_NONE, 1'b0);
          6'b010010: e = mk(10, GATE_NONE, 1'b0);
          6'b010100: e = mk(11, GATE_NONE, 1'b0);
          6'b010101: e = mk(12, GATE_NONE, 1'b0);
          6'b010111: e = mk(13, GATE_NONE, 1'b0);
          default:   e = mk(14 + int'(p) - 24, GATE_NONE, 1'b0);
        endcase
      end
      6'b001010: e = mk(44, GATE_NONE, 1'b0);
      6'b001011: e = mk(45, GATE_NONE, 1'b0);
      default: begin
        if (p >= 6'b100000 && p <= 6'b110111) begin
          e = mk(20 + int'(p) - 32, GATE_NONE, 1'b0);
        end else begin
          found = 1'b0;
        end
      end
    endcase
    if (found) return e;
    found = 1'b1;
    case (p)
      Pri19: e = decode_xo19(x10);
      Pri31: e = decode_xo31(x10);
      Pri63: e = decode_xo63(x10);
      default: e = Miss;
    endcase
    if (e.hit) return e;
    case (p)
      Pri59: e = decode_xo59_short(x5);
      Pri63: e = decode_xo63_short(x5);
      default: e = Miss;
    endcase
    found = e.hit;
    return e;
  endfunction

  function automatic entry_t decode_xo19(input logic [9:0] x);
    case (x)
      10'b0000000000: return mk(65, GATE_NONE, 1'b0);
      10'b0000010000: return mk(66, GATE_NONE, 1'b0);
      10'b0000100001: return mk(67, GATE_NONE, 1'b0);
      10'b0000110010: return mk(68, GATE_NONE, 1'b0);
      10'b0010000001: return mk(69, GATE_NONE, 1'b0);
      10'b0010010110: return mk(70, GATE_NONE, 1'b0);
      10'b0011000001: return mk(71, GATE_NONE, 1'b0);
      10'b0011100001: return mk(72, GATE_NONE, 1'b0);
      10'b0100000001: return mk(73, GATE_NONE, 1'b0);
      10'b0100100001: return mk(74, GATE_NONE, 1'b0);
      10'b0110100001: return mk(75, GATE_NONE, 1'b0);
      10'b0111000001: return mk(76, GATE_NONE, 1'b0);
      10'b1000010000: return mk(77, GATE_NONE, 1'b0);
      default:        return Miss;
    endcase
  endfunction

  function automatic entry_t decode_xo31(input logic [9:0] x);
    case (x)
      10'b0000001001: return mk(46, GATE_64, 1'b0);
      10'b0000010101: return mk(47, GATE_64, 1'b0);
      10'b0000011011: return mk(48, GATE_64, 1'b0);
      10'b0000110101: return mk(49, GATE_64, 1'b0);
      10'b0000111010: return mk(50, GATE_64, 1'b0);
      10'b0001000100: return mk(51, GATE_64, 1'b0);
      10'b0001001001: return mk(52, GATE_64, 1'b0);
      10'b0001010100: return mk(53, GATE_64, 1'b0);
      10'b0010010101: return mk(54, GATE_64, 1'b0);
      10'b0010110101: return mk(55, GATE_64, 1'b0);
      10'b0011101001, 10'b1011101001: return mk(56, GATE_64, 1'b0);
      10'b0101010101: return mk(57, GATE_64, 1'b0);
      10'b0101110101: return mk(58, GATE_64, 1'b0);
      10'b0110110010: return mk(59, GATE_64, 1'b0);
      10'b0111001001, 10'b1111001001: return mk(60, GATE_64, 1'b0);
      10'b0111101001, 10'b1111101001: return mk(61, GATE_64, 1'b0);
      10'b1000011011: return mk(62, GATE_64, 1'b0);
      10'b1100011010: return mk(63, GATE_64, 1'b0);
      10'b1111011010: return mk(64, GATE_64, 1'b0);
      10'b0000000000: return mk(78, GATE_NONE, 1'b0);
      10'b0000000100: return mk(79, GATE_NONE, 1'b0);
      10'b0000001000, 10'b1000001000: return mk(80, GATE_NONE, 1'b0);
      10'b0000001010, 10'b1000001010: return mk(81, GATE_NONE, 1'b0);
      10'b0000001011: return mk(82, GATE_NONE, 1'b0);
      10'b0000010011: return mk(83, GATE_NONE, 1'b0);
      10'b0000010100: return mk(84, GATE_NONE, 1'b0);
      10'b0000010111: return mk(85, GATE_NONE, 1'b0);
      10'b0000011000: return mk(86, GATE_NONE, 1'b0);
      10'b0000011010: return mk(87, GATE_NONE, 1'b0);
      10'b0000011100: return mk(88, GATE_NONE, 1'b0);
      10'b0000100000: return mk(89, GATE_NONE, 1'b0);
      10'b0000101000, 10'b1000101000: return mk(90, GATE_NONE, 1'b0);
      10'b0000110110: return mk(91, GATE_NONE, 1'b0);
      10'b0000110111: return mk(92, GATE_NONE, 1'b0);
      10'b0000111100: return mk(93, GATE_NONE, 1'b0);
      10'b0001001011: return mk(94, GATE_NONE, 1'b0);
      10'b0001010011: return mk(95, GATE_NONE, 1'b0);
      10'b0001010110: return mk(96, GATE_NONE, 1'b0);
      10'b0001010111: return mk(97, GATE_NONE, 1'b0);
      10'b0001101000, 10'b1001101000: return mk(98, GATE_NONE, 1'b0);
      10'b0001110111: return mk(99, GATE_NONE, 1'b0);
      10'b0001111100: return mk(100, GATE_NONE, 1'b0);
      10'b0010001000, 10'b1010001000: return mk(101, GATE_NONE, 1'b0);
      10'b0010001010, 10'b1010001010: return mk(102, GATE_NONE, 1'b0);
      10'b0010010000: return mk(103, GATE_NONE, 1'b0);
      10'b0010010010: return mk(104, GATE_NONE, 1'b0);
      10'b0010010111: return mk(105, GATE_NONE, 1'b0);
      10'b0010110111: return mk(106, GATE_NONE, 1'b0);
      10'b0011001000, 10'b1011001000: return mk(107, GATE_NONE, 1'b0);
      10'b0011001010, 10'b1011001010: return mk(108, GATE_NONE, 1'b0);
      10'b0011010111: return mk(109, GATE_NONE, 1'b0);
      10'b0011101000, 10'b1011101000: return mk(110, GATE_NONE, 1'b0);
      10'b0011101010, 10'b1011101010: return mk(111, GATE_NONE, 1'b0);
      10'b0011101011, 10'b1011101011: return mk(112, GATE_NONE, 1'b0);
      10'b0011110110: return mk(113, GATE_NONE, 1'b0);
      10'b0011110111: return mk(114, GATE_NONE, 1'b0);
      10'b0100001010, 10'b1100001010: return mk(115, GATE_NONE, 1'b0);
      10'b0100010110: return mk(116, GATE_NONE, 1'b0);
      10'b0100010111: return mk(117, GATE_NONE, 1'b0);
      10'b0100011100: return mk(118, GATE_NONE, 1'b0);
      10'b0100110110: return mk(119, GATE_NONE, 1'b0);
      10'b0100110111: return mk(120, GATE_NONE, 1'b0);
      10'b0100111100: return mk(121, GATE_NONE, 1'b0);
      10'b0101010111: return mk(122, GATE_NONE, 1'b0);
      10'b0101110011: return mk(123, GATE_NONE, 1'b0);
      10'b0101110111: return mk(124, GATE_NONE, 1'b0);
      10'b0110010111: return mk(125, GATE_NONE, 1'b0);
      10'b0110011100: return mk(126, GATE_NONE, 1'b0);
      10'b0110110110: return mk(127, GATE_NONE, 1'b0);
      10'b0110110111: return mk(128, GATE_NONE, 1'b0);
      10'b0110111100: return mk(129, GATE_NONE, 1'b0);
      10'b0111001011, 10'b1111001011: return mk(130, GATE_NONE, 1'b0);
      10'b0111010110: return mk(131, GATE_NONE, 1'b0);
      10'b0111011100: return mk(132, GATE_NONE, 1'b0);
      10'b0111101011, 10'b1111101011: return mk(133, GATE_NONE, 1'b0);
      10'b1000000000: return mk(134, GATE_NONE, 1'b0);
      10'b1000010101: return mk(135, GATE_NONE, 1'b0);
      10'b1000010110: return mk(136, GATE_NONE, 1'b0);
      10'b1000010111: return mk(137, GATE_NONE, 1'b0);
      10'b1000011000: return mk(138, GATE_NONE, 1'b0);
      10'b1000110111: return mk(139, GATE_NONE, 1'b0);
      10'b1001010101: return mk(140, GATE_NONE, 1'b0);
      10'b1001010110: return mk(141, GATE_NONE, 1'b0);
      10'b1001010111: return mk(142, GATE_NONE, 1'b0);
      10'b1001110111: return mk(143, GATE_NONE, 1'b0);
      10'b1010010101: return mk(144, GATE_NONE, 1'b0);
      10'b1010010110: return mk(145, GATE_NONE, 1'b0);
      10'b1010010111: return mk(146, GATE_NONE, 1'b0);
      10'b1010110111: return mk(147, GATE_NONE, 1'b0);
      10'b1011010101: return mk(148, GATE_NONE, 1'b0);
      10'b1011010111: return mk(149, GATE_NONE, 1'b0);
      10'b1011110111: return mk(150, GATE_NONE, 1'b0);
      10'b1100010110: return mk(151, GATE_NONE, 1'b0);
      10'b1100011000: return mk(152, GATE_NONE, 1'b0);
      10'b1100111000: return mk(153, GATE_NONE, 1'b0);
      10'b1101010110: return mk(154, GATE_NONE, 1'b0);
      10'b1110010110: return mk(155, GATE_NONE, 1'b0);
      10'b1110011010: return mk(156, GATE_NONE, 1'b0);
      10'b1110111010: return mk(157, GATE_NONE, 1'b0);
      10'b1111010110: return mk(158, GATE_NONE, 1'b0);
      10'b1111010111: return mk(159, GATE_NONE, 1'b0);
      10'b1111110110: return mk(160, GATE_NONE, 1'b0);
      10'b0101010011: return mk(179, GATE_NONE, 1'b0);
      10'b0111010011: return mk(180, GATE_NONE, 1'b0);
      10'b0011010010: return mk(181, GATE_32, 1'b1);
      10'b0011110010: return mk(182, GATE_32, 1'b1);
      10'b1001010011: return mk(183, GATE_32, 1'b1);
      10'b1010010011: return mk(184, GATE_32, 1'b1);
      10'b0111110010: return mk(185, GATE_64, 1'b1);
      10'b0100110010: return mk(186, GATE_NONE, 1'b1);
      10'b0101110010: return mk(187, GATE_NONE, 1'b1);
      10'b1000110110: return mk(188, GATE_NONE, 1'b1);
      default:        return Miss;
    endcase
  endfunction

  function automatic entry_t decode_xo63(input logic [9:0] x);
    case (x)
      10'b0000000000: return mk(161, GATE_NONE, 1'b0);
      10'b0000001100: return mk(162, GATE_NONE, 1'b0);
      10'b0000001110: return mk(163, GATE_NONE, 1'b0);
      10'b0000001111: return mk(164, GATE_NONE, 1'b0);
      10'b0000100000: return mk(165, GATE_NONE, 1'b0);
      10'b0000100110: return mk(166, GATE_NONE, 1'b0);
      10'b0000101000: return mk(167, GATE_NONE, 1'b0);
      10'b0001000000: return mk(168, GATE_NONE, 1'b0);
      10'b0001000110: return mk(169, GATE_NONE, 1'b0);
      10'b0001001000: return mk(170, GATE_NONE, 1'b0);
      10'b0010000110: return mk(171, GATE_NONE, 1'b0);
      10'b0010001000: return mk(172, GATE_NONE, 1'b0);
      10'b0100001000: return mk(173, GATE_NONE, 1'b0);
      10'b1001000111: return mk(174, GATE_NONE, 1'b0);
      10'b1011000111: return mk(175, GATE_NONE, 1'b0);
      10'b1100101110: return mk(176, GATE_NONE, 1'b0);
      10'b1100101111: return mk(177, GATE_NONE, 1'b0);
      10'b1101001110: return mk(178, GATE_NONE, 1'b0);
      default:        return Miss;
    endcase
  endfunction

  function automatic entry_t decode_xo59_short(input logic [4:0] x);
    case (x)
      5'b10010: return mk(189, GATE_NONE, 1'b0);
      5'b10100: return mk(190, GATE_NONE, 1'b0);
      5'b10101: return mk(191, GATE_NONE, 1'b0);
      5'b11001: return mk(192, GATE_NONE, 1'b0);
      5'b11100: return mk(193, GATE_NONE, 1'b0);
      5'b11101: return mk(194, GATE_NONE, 1'b0);
      5'b11110: return mk(195, GATE_NONE, 1'b0);
      5'b11111: return mk(196, GATE_NONE, 1'b0);
      5'b10110: return mk(205, GATE_64, 1'b0);
      5'b11000: return mk(206, GATE_64, 1'b0);
      default:  return Miss;
    endcase
  endfunction

  function automatic entry_t decode_xo63_short(input logic [4:0] x);
    case (x)
      5'b10010: return mk(197, GATE_NONE, 1'b0);
      5'b10100: return mk(198, GATE_NONE, 1'b0);
      5'b10101: return mk(199, GATE_NONE, 1'b0);
      5'b11001: return mk(200, GATE_NONE, 1'b0);
      5'b11100: return mk(201, GATE_NONE, 1'b0);
      5'b11101: return mk(202, GATE_NONE, 1'b0);
      5'b11110: return mk(203, GATE_NONE, 1'b0);
      5'b11111: return mk(204, GATE_NONE, 1'b0);
      5'b10110: return mk(207, GATE_NONE, 1'b0);
      5'b10111: return mk(208, GATE_NONE, 1'b0);
      5'b11010: return mk(209, GATE_NONE, 1'b0);
      default:  return Miss;
    endcase
  endfunction

  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t d;
    entry_t   e;
    logic     found;
    d.word = w;
    d.op = OpUndef;
    d.sup = 1'b0;
    e = lookup_entry(w[31:26], w[10:1], w[5:1], found);
    if (found) begin
      if (!((e.gate == GATE_64 && !is_64bit) || (e.gate == GATE_32 && is_64bit))) begin
        d.op = e.op;
        d.sup = e.sup;
      end
    end else if ((w & ScMask) == ScMatch) begin
      d.op = OpSc;
    end
    return d;
  endfunction

  // result side: random stall and compare against oldest expectation
  always @(posedge clk) begin
    decoded_t exp_d;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, m_axis_tdata);
        errors <= errors + 1;
      end else begin
        exp_d = pending_decodes.pop_front();
        if (m_axis_tdata[7:0] !== exp_d.op || m_axis_tdata[8] !== exp_d.sup ||
            m_axis_tdata[40:9] !== exp_d.word) begin
          $display("%0t word %h: expected op %0d sup %b, actual op %0d sup %b word %h",
                   $time, exp_d.word, exp_d.op, exp_d.sup, m_axis_tdata[7:0],
                   m_axis_tdata[8], m_axis_tdata[40:9]);
          errors <= errors + 1;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_model(input logic v);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    is_64bit = v;
  endtask

  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_decodes.push_back(decode_word(w));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [5:0]  p;
    w = $urandom;
    case ($urandom_range(5))
      0: p = Pri31;
      1: p = Pri63;
      2: p = Pri59;
      3: p = Pri19;
      4: p = 6'b010001;
      default: p = w[31:26];
    endcase
    w[31:26] = p;
    if ($urandom_range(1)) begin
      if (p == Pri59 || p == Pri63) w[5:1] = Xo5List[$urandom_range(5)];
      else w[10:1] = Xo31List[$urandom_range(13)];
    end
    return w;
  endfunction

  initial begin
    row_t     r;
    decoded_t d;
    rows.push_back('{1'b0, 1'b0, 32'h0000_0000, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 8'd204, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h0800_0000, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h4400_0002, 1'b1, OpSc, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hBBFF_FFFD, 1'b1, 8'd34, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_0012, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_01A4, 1'b1, 8'd181, 1'b1});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_02E4, 1'b1, 8'd187, 1'b1});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_03E4, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hEC00_002C, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h4C00_0000, 1'b0, 8'd0, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hFC00_0000, 1'b0, 8'd0, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hEC00_0024, 1'b0, 8'd0, 1'b0});
    rows.push_back('{1'b1, 1'b1, 32'h0800_0000, 1'b1, 8'd1, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_0012, 1'b1, 8'd46, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_01A4, 1'b1, OpUndef, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_03E4, 1'b1, 8'd185, 1'b1});
    rows.push_back('{1'b0, 1'b0, 32'hEC00_002C, 1'b1, 8'd205, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h7C00_026C, 1'b0, 8'd0, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'hFC00_002E, 1'b0, 8'd0, 1'b0});
    rows.push_back('{1'b0, 1'b0, 32'h4400_0000, 1'b1, OpUndef, 1'b0});
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.cfg_wr) begin
        drain();
        write_model(r.cfg_val);
      end
      if (r.typed) begin
        d = decode_word(r.word);
        if (d.op !== r.exp_op || d.sup !== r.exp_sup) begin
          $display("%0t table word %h: expected op %0d sup %b, predicted op %0d sup %b",
                   $time, r.word, r.exp_op, r.exp_sup, d.op, d.sup);
          table_errors++;
        end
      end
      send_word(r.word);
    end
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      write_model(phase[0]);
      send_idle = (phase % 4 == 1 || phase % 4 == 3) ? 66 : 0;
      recv_stall = (phase % 4 == 2 || phase % 4 == 3) ? 66 : 0;
      if (phase % 4 == 3) begin
        send_idle = 15;
        recv_stall = 15;
      end
      for (int n = 0; n < 175; n++) begin
        if (n == 90) drain();
        send_word(random_word());
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && table_errors == 0) begin
      $display("powerpc_instruction_decoder_unit: match");
    end else begin
      $display("powerpc_instruction_decoder_unit: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/ppcdec_pkg.sv
src/powerpc_instruction_decoder_unit.sv
sim/powerpc_instruction_decoder_unit_test.sv
